>>> design/lpic_pkg.sv
`default_nettype none

package lpic_pkg;

	localparam int unsigned VAL_W = 64;
	localparam int unsigned MAG_W = 63;
	localparam int unsigned CNT_W = 21;
	localparam int unsigned TOL_W = 33;
	localparam int unsigned IDX_W = 3;

	localparam logic [VAL_W-1:0] NEG_INF = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] POS_INF = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [MAG_W-1:0] SAT63   = {MAG_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(429);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_PRIMAL_TOL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_DUAL_TOL     = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAXIMIZE     = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRIMAL_VALID = 3'd3;
	localparam logic [IDX_W-1:0] REG_DUAL_VALID   = 3'd4;

	typedef enum logic [1:0] {
		ST_NONE       = 2'd0,
		ST_INFEASIBLE = 2'd1,
		ST_FEASIBLE   = 2'd2
	} lpic_status_t;

	// differences of one variable, after the first compute stage
	typedef struct packed {
		logic signed [VAL_W:0] dl;      // lower - value
		logic signed [VAL_W:0] dv;      // value - upper
		logic [VAL_W-1:0]      dl_mag;  // |lower - value|
		logic [VAL_W-1:0]      dv_mag;  // |value - upper|
		logic                  lo_fin;
		logic                  up_fin;
		logic                  lo_lt_up;
		logic                  dneg;    // effective dual sign
		logic [VAL_W-1:0]      dmag;    // |dual|
		logic                  last;
	} lpic_diff_t;

	// per-variable infeasibilities
	typedef struct packed {
		logic [MAG_W-1:0] pinf;
		logic             p_over;
		logic [MAG_W-1:0] dinf;
		logic             d_over;
		logic             last;
	} lpic_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] pcnt;
		logic [MAG_W-1:0] pmax;
		logic [MAG_W-1:0] psum;
		logic [CNT_W-1:0] dcnt;
		logic [MAG_W-1:0] dmax;
		logic [MAG_W-1:0] dsum;
		lpic_status_t     pst;
		lpic_status_t     dst;
	} lpic_result_t;

endpackage

`default_nettype wire

>>> design/lpic_eval.sv
`default_nettype none

// Primal and dual infeasibility of one variable from its precomputed differences.
module lpic_eval
	import lpic_pkg::*;
(
	input  wire lpic_diff_t       diff,
	input  wire logic [TOL_W-1:0] primal_tol,
	input  wire logic [TOL_W-1:0] dual_tol,
	output lpic_item_t            item
);

	logic [VAL_W-1:0] ptol_ext;
	logic [MAG_W-1:0] dtol_ext;
	logic             p_lo, p_up, at_bound, at_lower;
	logic [VAL_W-1:0] pinf_w, dinf_w;

	assign ptol_ext = {{(VAL_W-TOL_W){1'b0}}, primal_tol};
	assign dtol_ext = {{(MAG_W-TOL_W){1'b0}}, dual_tol};

	always_comb begin
		p_lo = diff.lo_fin && !diff.dl[VAL_W] && (diff.dl_mag > ptol_ext);
		p_up = diff.up_fin && !diff.dv[VAL_W] && (diff.dv_mag > ptol_ext);
		if (p_lo) begin
			pinf_w = diff.dl_mag;
		end else if (p_up) begin
			pinf_w = diff.dv_mag;
		end else begin
			pinf_w = '0;
		end

		at_bound = (diff.lo_fin && (diff.dl_mag <= ptol_ext)) ||
		           (diff.up_fin && (diff.dv_mag <= ptol_ext));
		// closer to lower when value - lower < upper - value, i.e. dv < dl
		if (!diff.lo_fin) begin
			at_lower = 1'b0;
		end else if (!diff.up_fin) begin
			at_lower = 1'b1;
		end else begin
			at_lower = diff.dv < diff.dl;
		end

		if (!at_bound) begin
			dinf_w = diff.dmag;
		end else if (!diff.lo_lt_up) begin
			dinf_w = '0;
		end else if (at_lower) begin
			dinf_w = diff.dneg ? diff.dmag : '0;
		end else begin
			dinf_w = diff.dneg ? '0 : diff.dmag;
		end

		item.pinf   = pinf_w[VAL_W-1] ? SAT63 : pinf_w[MAG_W-1:0];
		item.p_over = p_lo || p_up;
		item.dinf   = dinf_w[VAL_W-1] ? SAT63 : dinf_w[MAG_W-1:0];
		item.d_over = item.dinf > dtol_ext;
		item.last   = diff.last;
	end

endmodule

`default_nettype wire

>>> design/lpic_acc.sv
`default_nettype none

// Counts, maxima and saturating sums; cleared after the last variable.
module lpic_acc
	import lpic_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       upd,
	input  wire lpic_item_t item,
	input  wire logic       primal_on,
	input  wire logic       dual_on,
	output lpic_result_t    res
);

	logic [CNT_W-1:0] pcnt_q, dcnt_q, pcnt_n, dcnt_n;
	logic [MAG_W-1:0] pmax_q, psum_q, dmax_q, dsum_q;
	logic [MAG_W-1:0] pmax_n, psum_n, dmax_n, dsum_n;
	logic [MAG_W:0]   psum_w, dsum_w;
	logic             p_take, d_take;

	always_comb begin
		p_take = primal_on;
		d_take = primal_on && dual_on;

		pcnt_n = pcnt_q;
		pmax_n = pmax_q;
		psum_n = psum_q;
		psum_w = {1'b0, psum_q} + {1'b0, item.pinf};
		if (p_take && item.p_over) begin
			if (pcnt_q != CNT_MAX) begin
				pcnt_n = pcnt_q + CNT_W'(1);
			end
			if (item.pinf > pmax_q) begin
				pmax_n = item.pinf;
			end
			psum_n = psum_w[MAG_W] ? SAT63 : psum_w[MAG_W-1:0];
		end

		dcnt_n = dcnt_q;
		dmax_n = dmax_q;
		dsum_n = dsum_q;
		dsum_w = {1'b0, dsum_q} + {1'b0, item.dinf};
		if (d_take) begin
			if (item.d_over && (dcnt_q != CNT_MAX)) begin
				dcnt_n = dcnt_q + CNT_W'(1);
			end
			if (item.dinf > dmax_q) begin
				dmax_n = item.dinf;
			end
			dsum_n = dsum_w[MAG_W] ? SAT63 : dsum_w[MAG_W-1:0];
		end

		res = '0;
		res.pst = ST_NONE;
		res.dst = ST_NONE;
		if (primal_on) begin
			res.pcnt = pcnt_n;
			res.pmax = pmax_n;
			res.psum = psum_n;
			res.pst  = (pcnt_n == '0) ? ST_FEASIBLE : ST_INFEASIBLE;
			if (dual_on) begin
				res.dcnt = dcnt_n;
				res.dmax = dmax_n;
				res.dsum = dsum_n;
				res.dst  = (dcnt_n == '0) ? ST_FEASIBLE : ST_INFEASIBLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			pmax_q <= '0;
			psum_q <= '0;
			dcnt_q <= '0;
			dmax_q <= '0;
			dsum_q <= '0;
		end else if (upd) begin
			if (item.last) begin
				pcnt_q <= '0;
				pmax_q <= '0;
				psum_q <= '0;
				dcnt_q <= '0;
				dmax_q <= '0;
				dsum_q <= '0;
			end else begin
				pcnt_q <= pcnt_n;
				pmax_q <= pmax_n;
				psum_q <= psum_n;
				dcnt_q <= dcnt_n;
				dmax_q <= dmax_n;
				dsum_q <= dsum_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/lp_infeasibility_checker.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: bounds, value, dual; tuser: is_row; tlast
// m_*       out        m_tvalid / m_tready  tdata: counts, maxima, sums, two statuses
// cfg_*     in         cfg_valid/cfg_ready  cfg_index selects register, cfg_data value
//
// One variable per cycle sustained unless stalled. An item passes the input
// register (s1), the difference stage (s2), the evaluation stage (s3) and is
// folded into the accumulators as it leaves s3; a last item also loads the
// result register, which drives m_tvalid. Only a last item held in s3 while
// the result register is still occupied stalls the pipe. Reset clears the
// pipe, the accumulators and loads the register defaults.
`default_nettype none

module lp_infeasibility_checker
	import lpic_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// [63:0] lower_bound, [127:64] upper_bound, [191:128] point_value,
	// [255:192] dual_value
	input  wire logic [4*VAL_W-1:0] s_tdata,
	// [0] is_row
	input  wire logic [0:0]         s_tuser,
	input  wire logic               s_tlast,

	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// [20:0] primal_count, [83:21] primal_max, [146:84] primal_sum,
	// [167:147] dual_count, [230:168] dual_max, [293:231] dual_sum,
	// [295:294] primal verdict, [297:296] dual verdict, [303:298] zero
	output logic [303:0]            m_tdata,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [TOL_W-1:0]   cfg_data
);

	// configuration registers
	logic [TOL_W-1:0] ptol_q, dtol_q;
	logic             maximize_q, pvalid_q, dvalid_q;

	// stage s1: raw input
	logic                    v_s1;
	logic signed [VAL_W-1:0] lo_s1, up_s1, val_s1, du_s1;
	logic                    row_s1, last_s1;

	// stage s2 and s3
	logic       v_s2, v_s3;
	lpic_diff_t diff_c, diff_s2;
	lpic_item_t item_c, item_s3;

	// output register
	logic         m_valid_q;
	lpic_result_t res_c, out_q;

	logic adv1, adv2, adv3, free1, free2, free3, in_xfer;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptol_q     <= TOL_RST;
			dtol_q     <= TOL_RST;
			maximize_q <= 1'b0;
			pvalid_q   <= 1'b0;
			dvalid_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PRIMAL_TOL:   ptol_q     <= cfg_data;
				REG_DUAL_TOL:     dtol_q     <= cfg_data;
				REG_MAXIMIZE:     maximize_q <= cfg_data[0];
				REG_PRIMAL_VALID: pvalid_q   <= cfg_data[0];
				REG_DUAL_VALID:   dvalid_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// a last item may only leave s3 when the result register can take it
	assign adv3     = v_s3 && (!item_s3.last || !m_valid_q || m_tready);
	assign free3    = !v_s3 || adv3;
	assign adv2     = v_s2 && free3;
	assign free2    = !v_s2 || adv2;
	assign adv1     = v_s1 && free2;
	assign free1    = !v_s1 || adv1;
	assign s_tready = free1;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			v_s1 <= (v_s1 && !adv1) || in_xfer;
			v_s2 <= (v_s2 && !adv2) || adv1;
			v_s3 <= (v_s3 && !adv3) || adv2;
			if (adv3 && item_s3.last) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- s1: input register ----------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lo_s1   <= s_tdata[VAL_W-1:0];
			up_s1   <= s_tdata[2*VAL_W-1:VAL_W];
			val_s1  <= s_tdata[3*VAL_W-1:2*VAL_W];
			du_s1   <= s_tdata[4*VAL_W-1:3*VAL_W];
			row_s1  <= s_tuser[0];
			last_s1 <= s_tlast;
		end
	end

	// ---------------- s1 -> s2: exact differences ----------------
	// both directions are subtracted in parallel so the magnitude is a mux
	logic signed [VAL_W:0] lo_x, up_x, val_x, du_x, nl, nv, ndu;

	always_comb begin
		lo_x  = {lo_s1[VAL_W-1], lo_s1};
		up_x  = {up_s1[VAL_W-1], up_s1};
		val_x = {val_s1[VAL_W-1], val_s1};
		du_x  = {du_s1[VAL_W-1], du_s1};
		nl    = val_x - lo_x;
		nv    = up_x - val_x;
		ndu   = -du_x;

		diff_c.dl       = lo_x - val_x;
		diff_c.dv       = val_x - up_x;
		diff_c.dl_mag   = diff_c.dl[VAL_W] ? nl[VAL_W-1:0] : diff_c.dl[VAL_W-1:0];
		diff_c.dv_mag   = diff_c.dv[VAL_W] ? nv[VAL_W-1:0] : diff_c.dv[VAL_W-1:0];
		diff_c.lo_fin   = lo_s1 != NEG_INF;
		diff_c.up_fin   = up_s1 != POS_INF;
		diff_c.lo_lt_up = lo_s1 < up_s1;
		// row duals and maximization flip the sign
		diff_c.dneg     = du_s1[VAL_W-1] ^ row_s1 ^ maximize_q;
		diff_c.dmag     = du_s1[VAL_W-1] ? ndu[VAL_W-1:0] : du_s1;
		diff_c.last     = last_s1;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			diff_s2 <= diff_c;
		end
	end

	// ---------------- s2 -> s3: infeasibilities ----------------
	lpic_eval u_eval (
		.diff       (diff_s2),
		.primal_tol (ptol_q),
		.dual_tol   (dtol_q),
		.item       (item_c)
	);

	always_ff @(posedge clk) begin
		if (adv2) begin
			item_s3 <= item_c;
		end
	end

	// ---------------- s3: accumulate ----------------
	lpic_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv3),
		.item      (item_s3),
		.primal_on (pvalid_q),
		.dual_on   (dvalid_q),
		.res       (res_c)
	);

	always_ff @(posedge clk) begin
		if (adv3 && item_s3.last) begin
			out_q <= res_c;
		end
	end

	// ---------------- result port ----------------
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, out_q.dst, out_q.pst, out_q.dsum, out_q.dmax, out_q.dcnt,
	                   out_q.psum, out_q.pmax, out_q.pcnt};

	// ---------------- assertions ----------------
	a_no_primal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_q.pst == ST_NONE) |->
		(out_q.pcnt == '0 && out_q.pmax == '0 && out_q.psum == '0 && out_q.dst == ST_NONE))
		else $error("no-solution result carries primal data");

	a_feasible: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_q.pst == ST_FEASIBLE) |-> (out_q.pcnt == '0 && out_q.pmax == '0))
		else $error("feasible primal status with infeasibility recorded");

	a_max_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (out_q.pmax <= out_q.psum && out_q.dmax <= out_q.dsum))
		else $error("maximum exceeds saturating sum");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv3 && item_s3.last) |=> (m_valid_q && out_q == $past(res_c)))
		else $error("last item did not load the result register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && item_s3.last && m_valid_q && !m_tready) |-> !adv3)
		else $error("last item left s3 over a pending result");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lpic_pkg::*;

	localparam int          WATCHDOG_LIMIT = 4000; // quiet cycles before giving up
	localparam int          LONG_HOLD      = 300;  // receiver hold-off for the pressure phase
	localparam int          DRAIN_CYCLES   = 8;    // pipe is four deep, leave some slack
	localparam int          PHASE_ITEMS    = 60;
	localparam logic [63:0] ONE_Q          = 64'h1_0000_0000; // 1.0 in Q32.32
	localparam logic [63:0] HALF_Q         = 64'h0_8000_0000; // 0.5 in Q32.32
	localparam logic [32:0] TOL_MAX        = 33'h1_0000_0000;

	// one variable of the problem as the sender sees it
	typedef struct packed {
		logic        is_row;
		logic [63:0] lo;
		logic [63:0] up;
		logic [63:0] val;
		logic [63:0] du;
		logic        last;
	} lp_var_t;

	// who idles: sender 38% / receiver 76%, the reverse, or nobody
	typedef enum logic [1:0] {
		PACE_RX_SLOW,
		PACE_TX_SLOW,
		PACE_FULL
	} pace_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [4*VAL_W-1:0] s_tdata   = '0;
	logic [0:0]         s_tuser   = '0;
	logic               s_tlast   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [303:0]       m_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [TOL_W-1:0]   cfg_data  = '0;

	lp_infeasibility_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: register copies and the running tallies
	// ------------------------------------------------------------------
	logic [32:0] tol_primal  = TOL_RST;
	logic [32:0] tol_dual    = TOL_RST;
	logic        maximize_on = 1'b0;
	logic        primal_on   = 1'b0;
	logic        dual_on     = 1'b0;

	logic [20:0] pri_count = '0;
	logic [62:0] pri_peak  = '0;
	logic [62:0] pri_total = '0;
	logic [20:0] dua_count = '0;
	logic [62:0] dua_peak  = '0;
	logic [62:0] dua_total = '0;

	lp_var_t      pending_vars[$];    // filled by the stimulus, drained by the driver
	lpic_result_t awaited_reports[$]; // reports predicted, not yet seen on m_*
	lp_var_t      in_flight;          // item currently offered on s_*

	pace_t pace          = PACE_RX_SLOW;
	int    hold_requests = 0;
	int    hold_served   = 0;
	int    hold_left     = 0;
	int    mismatches    = 0;
	int    quiet_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// sign-extend a Q32.32 code so that differences are exact
	function automatic logic signed [65:0] sx(input logic [63:0] x);
		return {{2{x[63]}}, x};
	endfunction

	function automatic logic [63:0] mag64(input logic signed [65:0] d);
		return d[65] ? 64'(-d) : d[63:0];
	endfunction

	// count / peak / saturating sum of one infeasibility
	task automatic fold_into_tally(inout logic [20:0] cnt, inout logic [62:0] peak,
			inout logic [62:0] total, input logic [63:0] x, input logic counted);
		logic [62:0] xs;
		logic [63:0] sum;
		xs = (x > {1'b0, SAT63}) ? SAT63 : x[62:0];
		if (counted && cnt != CNT_MAX)
			cnt = cnt + 1'b1;
		if (xs > peak)
			peak = xs;
		sum = {1'b0, total} + {1'b0, xs};
		total = (sum > {1'b0, SAT63}) ? SAT63 : sum[62:0];
	endtask

	// Per-variable infeasibility update; a last item closes the problem and
	// queues the report it must produce.
	task automatic fold_variable(input lp_var_t v);
		logic signed [65:0] dl, dv, d_low, d_high;
		logic [63:0]        dl_mag, dv_mag, pinf, dmag, dinf;
		logic               lo_fin, up_fin, dneg, at_bound, at_lower;
		lpic_result_t       r;
		lo_fin = (v.lo != NEG_INF);
		up_fin = (v.up != POS_INF);
		dl = sx(v.lo) - sx(v.val);
		dv = sx(v.val) - sx(v.up);
		dl_mag = mag64(dl);
		dv_mag = mag64(dv);
		if (primal_on) begin
			pinf = '0;
			if (lo_fin && !dl[65] && dl_mag > tol_primal)
				pinf = dl_mag;
			else if (up_fin && !dv[65] && dv_mag > tol_primal)
				pinf = dv_mag;
			if (pinf != 0)
				fold_into_tally(pri_count, pri_peak, pri_total, pinf, 1'b1);

			if (dual_on) begin
				dneg = v.du[63];
				dmag = dneg ? -v.du : v.du;
				// rows and maximization flip the sense of the dual
				dneg = dneg ^ v.is_row ^ maximize_on;
				at_bound = (lo_fin && dl_mag <= tol_primal) ||
					(up_fin && dv_mag <= tol_primal);
				if (!at_bound) begin
					dinf = dmag;
				end else if (sx(v.lo) < sx(v.up)) begin
					d_low  = sx(v.val) - sx(v.lo);
					d_high = sx(v.up) - sx(v.val);
					if (!lo_fin)
						at_lower = 1'b0;
					else if (!up_fin)
						at_lower = 1'b1;
					else
						at_lower = d_low < d_high;
					if (at_lower)
						dinf = dneg ? dmag : '0;
					else
						dinf = dneg ? '0 : dmag;
				end else begin
					dinf = '0; // fixed or crossed bounds
				end
				if (dinf > {1'b0, SAT63})
					dinf = {1'b0, SAT63};
				fold_into_tally(dua_count, dua_peak, dua_total, dinf, dinf > tol_dual);
			end
		end

		if (v.last) begin
			r = '0;
			if (primal_on) begin
				r.pcnt = pri_count;
				r.pmax = pri_peak;
				r.psum = pri_total;
				r.pst  = (pri_count == 0) ? ST_FEASIBLE : ST_INFEASIBLE;
				if (dual_on) begin
					r.dcnt = dua_count;
					r.dmax = dua_peak;
					r.dsum = dua_total;
					r.dst  = (dua_count == 0) ? ST_FEASIBLE : ST_INFEASIBLE;
				end else begin
					r.dst = ST_NONE;
				end
			end else begin
				r.pst = ST_NONE;
				r.dst = ST_NONE;
			end
			awaited_reports.push_back(r);
			pri_count = '0;
			pri_peak  = '0;
			pri_total = '0;
			dua_count = '0;
			dua_peak  = '0;
			dua_total = '0;
		end
	endtask

	function automatic lp_var_t make_var(input logic row, input logic [63:0] lo,
			input logic [63:0] up, input logic [63:0] val, input logic [63:0] du,
			input logic last);
		lp_var_t v;
		v.is_row = row;
		v.lo     = lo;
		v.up     = up;
		v.val    = val;
		v.du     = du;
		v.last   = last;
		return v;
	endfunction

	// Mostly well-formed variables: values placed around the bounds at the
	// tolerance edge, duals around the dual tolerance, plus some pure noise.
	function automatic lp_var_t random_variable(input logic row, input logic last);
		lp_var_t     v;
		logic [31:0] ipart;
		logic [63:0] base, span, off, doff;
		ipart = $urandom_range(0, 2000) - 1000;
		base  = {ipart, 32'($urandom)};
		case ($urandom_range(0, 9))
			0: span = '0;                                           // fixed
			1: span = -{32'($urandom_range(0, 3)), 32'($urandom)};  // crossed
			2, 3: span = {31'b0, tol_primal} << $urandom_range(0, 1); // narrow
			default: span = {32'($urandom_range(0, 50)), 32'($urandom)};
		endcase
		off = {31'b0, tol_primal} + 64'($urandom_range(0, 2)) - 64'd1;
		v.is_row = row;
		v.last   = last;
		v.lo     = base;
		v.up     = base + span;
		case ($urandom_range(0, 7))
			0: v.val = base + (span >> 1);
			1: v.val = base - off;
			2: v.val = base + off;
			3: v.val = v.up + off;
			4: v.val = v.up - off;
			5: v.val = base - {32'($urandom_range(1, 100)), 32'($urandom)};
			6: v.val = v.up + {32'($urandom_range(1, 100)), 32'($urandom)};
			default: v.val = {$urandom, $urandom};
		endcase
		if ($urandom_range(0, 6) == 0)
			v.lo = NEG_INF;
		if ($urandom_range(0, 6) == 0)
			v.up = POS_INF;
		doff = {31'b0, tol_dual} + 64'($urandom_range(0, 2)) - 64'd1;
		case ($urandom_range(0, 5))
			0: v.du = '0;
			1: v.du = {32'($urandom_range(0, 20)) - 32'd10, 32'($urandom)};
			2: v.du = doff;
			3: v.du = -doff;
			4: v.du = $urandom_range(0, 1) ? NEG_INF : POS_INF;
			default: v.du = {$urandom, $urandom};
		endcase
		if ($urandom_range(0, 12) == 0) begin
			v.lo  = {$urandom, $urandom};
			v.up  = {$urandom, $urandom};
			v.val = {$urandom, $urandom};
			v.du  = {$urandom, $urandom};
		end
		return v;
	endfunction

	// columns first, then rows; only the closing item carries tlast
	task automatic queue_problem(input int len);
		int n_cols;
		n_cols = $urandom_range(0, len);
		for (int i = 0; i < len; i++)
			pending_vars.push_back(random_variable(i >= n_cols, i == len - 1));
	endtask

	function automatic logic sender_idles();
		case (pace)
			PACE_RX_SLOW: return $urandom_range(0, 99) < 38;
			PACE_TX_SLOW: return $urandom_range(0, 99) < 76;
			default:      return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_idles();
		case (pace)
			PACE_RX_SLOW: return $urandom_range(0, 99) < 76;
			PACE_TX_SLOW: return $urandom_range(0, 99) < 38;
			default:      return 1'b0;
		endcase
	endfunction

	// one register transfer on the cfg channel; the copy follows on acceptance
	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [TOL_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PRIMAL_TOL:   tol_primal  = data;
			REG_DUAL_TOL:     tol_dual    = data;
			REG_MAXIMIZE:     maximize_on = data[0];
			REG_PRIMAL_VALID: primal_on   = data[0];
			REG_DUAL_VALID:   dual_on     = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_problem_config(input logic [32:0] ptol, input logic [32:0] dtol,
			input logic mx, input logic pv, input logic dv);
		write_register(REG_PRIMAL_TOL, ptol);
		write_register(REG_DUAL_TOL, dtol);
		write_register(REG_MAXIMIZE, 33'(mx));
		write_register(REG_PRIMAL_VALID, 33'(pv));
		write_register(REG_DUAL_VALID, 33'(dv));
	endtask

	// Sender pause: everything offered, accepted and reported, then a wait of
	// DRAIN_CYCLES so that no item without a report is still in the pipe.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_vars.size() != 0 || s_tvalid || awaited_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string label, input logic [62:0] want,
			input logic [62:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, label, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the pending variables; the prediction is made on the
	// transfer of each one.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				fold_variable(in_flight);
			if (!s_tvalid || s_tready) begin
				if (pending_vars.size() != 0 && !sender_idles()) begin
					in_flight = pending_vars.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {in_flight.du, in_flight.val, in_flight.up, in_flight.lo};
					s_tuser  <= in_flight.is_row;
					s_tlast  <= in_flight.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request so
	// that reports pile up and the block has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= LONG_HOLD;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= !receiver_idles();
		end
	end

	// Monitor: every report transfer against the oldest prediction
	always @(posedge clk) begin
		lpic_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_reports.size() == 0) begin
				mismatches++;
				$display("%0t: report expected none got %0h", $time, m_tdata);
			end else begin
				want = awaited_reports.pop_front();
				check_field("primal_count", 63'(want.pcnt), 63'(m_tdata[20:0]));
				check_field("primal_max", want.pmax, m_tdata[83:21]);
				check_field("primal_sum", want.psum, m_tdata[146:84]);
				check_field("dual_count", 63'(want.dcnt), 63'(m_tdata[167:147]));
				check_field("dual_max", want.dmax, m_tdata[230:168]);
				check_field("dual_sum", want.dsum, m_tdata[293:231]);
				check_field("primal verdict", 63'(want.pst), 63'(m_tdata[295:294]));
				check_field("dual verdict", 63'(want.dst), 63'(m_tdata[297:296]));
			end
		end
	end

	// Watchdog: too long without any transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int          queued;
		int          frame_len;
		logic [32:0] pt, dt;
		logic        mx, pv, dv;
		pace = PACE_RX_SLOW;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: no primal solution, so an all-zero report
		pending_vars.push_back(make_var(1'b0, '0, ONE_Q, HALF_Q, 64'd5, 1'b0));
		pending_vars.push_back(make_var(1'b0, POS_INF, POS_INF, NEG_INF, NEG_INF, 1'b0));
		pending_vars.push_back(make_var(1'b1, '0, '0, '0, '0, 1'b1));
		wait_drained();

		// directed problem, tolerance 1.0 so the midpoint rule is reachable
		set_problem_config(TOL_MAX, '0, 1'b0, 1'b1, 1'b1);
		// exactly at the midpoint: counts as the upper bound
		pending_vars.push_back(make_var(1'b0, '0, ONE_Q, HALF_Q, 64'd5, 1'b0));
		// just below the midpoint: lower bound, negative dual is wrong
		pending_vars.push_back(make_var(1'b0, '0, ONE_Q, HALF_Q - 1, -64'd7, 1'b0));
		// infinite lower: upper side; infinite upper: lower side
		pending_vars.push_back(make_var(1'b0, NEG_INF, '0, '0, 64'd3, 1'b0));
		pending_vars.push_back(make_var(1'b0, '0, POS_INF, '0, -64'd3, 1'b0));
		// free variable, most negative dual saturates
		pending_vars.push_back(make_var(1'b0, NEG_INF, POS_INF, POS_INF, NEG_INF, 1'b0));
		// fixed and crossed bounds: no dual infeasibility
		pending_vars.push_back(make_var(1'b0, ONE_Q, ONE_Q, ONE_Q, POS_INF, 1'b0));
		pending_vars.push_back(make_var(1'b0, ONE_Q, '0, HALF_Q, 64'd9, 1'b0));
		// largest finite distances both ways: primal sum saturates
		pending_vars.push_back(make_var(1'b0, POS_INF, POS_INF, NEG_INF, '0, 1'b0));
		pending_vars.push_back(make_var(1'b0, NEG_INF, NEG_INF, POS_INF, '0, 1'b0));
		// rows flip the dual sense at both bounds
		pending_vars.push_back(make_var(1'b1, '0, ONE_Q, '0, 64'd4, 1'b0));
		pending_vars.push_back(make_var(1'b1, '0, ONE_Q, ONE_Q, -64'd4, 1'b0));
		// strictly between wide bounds: absolute dual
		pending_vars.push_back(make_var(1'b1, '0, 10 * ONE_Q, 5 * ONE_Q, -64'd2, 1'b0));
		// outside by exactly the tolerance, then by one code more
		pending_vars.push_back(make_var(1'b1, '0, ONE_Q, 2 * ONE_Q, 64'd1, 1'b0));
		pending_vars.push_back(make_var(1'b1, '0, ONE_Q, -ONE_Q - 1, '0, 1'b0));
		pending_vars.push_back(make_var(1'b1, '0, '0, '0, '0, 1'b1));
		wait_drained();

		// random phases, each under its own settings and pacing
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					pt = TOL_RST; dt = 33'($urandom_range(0, 1 << 20)); mx = 1'b0;
					pv = 1'b1; dv = 1'b1; pace = PACE_RX_SLOW;
				end
				1: begin
					pt = '0; dt = '0; mx = 1'b1;
					pv = 1'b1; dv = 1'b0; pace = PACE_TX_SLOW;
				end
				2: begin
					pt = TOL_MAX; dt = TOL_MAX; mx = 1'b0;
					pv = 1'b1; dv = 1'b1; pace = PACE_FULL;
				end
				3: begin
					pt = {1'b0, $urandom}; dt = 33'($urandom_range(0, 4096)); mx = 1'b1;
					pv = 1'b0; dv = 1'b1; pace = PACE_RX_SLOW;
				end
				4: begin
					pt = 33'($urandom_range(0, 4096)); dt = {1'b0, $urandom};
					mx = 1'($urandom_range(0, 1)); pv = 1'b1; dv = 1'b1;
					pace = PACE_TX_SLOW;
				end
				default: begin
					pt = 33'd1; dt = TOL_MAX; mx = 1'b1;
					pv = 1'b1; dv = 1'b1; pace = PACE_FULL;
				end
			endcase
			set_problem_config(pt, dt, mx, pv, dv);
			// pressure phase: one- and two-variable problems against a stalled receiver
			if (phase == 2)
				hold_requests++;
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				if (phase == 2)
					frame_len = $urandom_range(1, 2);
				else if ($urandom_range(0, 9) == 0)
					frame_len = $urandom_range(20, 40);
				else
					frame_len = $urandom_range(1, 10);
				queue_problem(frame_len);
				queued += frame_len;
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
